// File: src/wca_pkg.sv
// ----------------------------------------------------------------------------
// wca_pkg: shared types and arithmetic for the waveform capture block
// display range state, top floor constants and the x*1.05 growth helpers
// ----------------------------------------------------------------------------
`default_nettype none

package wca_pkg;

	localparam int HISTORY_DEPTH_DEF = 256;
	localparam int IDX_W             = 8;
	localparam int SAMPLE_W          = 16;
	localparam int PAIR_W            = 2 * SAMPLE_W;

	localparam logic        [SAMPLE_W-1:0] TOP_FLOOR_V = 16'd100;
	localparam logic signed [SAMPLE_W-1:0] TOP_FLOOR_I = 16'sd100;

	// peaks and sticky display tops
	typedef struct packed {
		logic                       started;
		logic        [SAMPLE_W-1:0] vtop;
		logic signed [SAMPLE_W-1:0] itop;
		logic        [SAMPLE_W-1:0] vpeak;
		logic signed [SAMPLE_W-1:0] ipeak;
	} range_t;

	// x + floor(x*205/4096), saturated to 16 bit unsigned
	function automatic logic [SAMPLE_W-1:0] grow_v(input logic [SAMPLE_W-1:0] x);
		logic [23:0] p;
		logic [16:0] s;
		p = 24'(x) * 24'd205;
		s = {1'b0, x} + 17'(p[23:12]);
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	// x + floor(x*205/4096), saturated to 16 bit two's complement
	function automatic logic signed [SAMPLE_W-1:0] grow_i(
		input logic signed [SAMPLE_W-1:0] x
	);
		logic signed [23:0] p;
		logic        [16:0] s;
		p = $signed({{8{x[15]}}, x}) * $signed(24'd205);
		s = {x[15], x} + {{5{p[23]}}, p[23:12]};
		if (s[16] != s[15]) begin
			return s[16] ? 16'sh8000 : 16'sh7FFF;
		end
		return $signed(s[15:0]);
	endfunction

endpackage

`default_nettype wire

// File: src/wca_ram.sv
// ----------------------------------------------------------------------------
// wca_ram: generic single write port ram with registered read
// read of the address being written returns the old contents
// ----------------------------------------------------------------------------
`default_nettype none

module wca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/wca_range.sv
// ----------------------------------------------------------------------------
// wca_range: peak tracking and sticky display top update
// next range state for one captured sample pair
// ----------------------------------------------------------------------------
`default_nettype none

module wca_range (
	input  logic        [15:0] voltage,
	input  logic signed [15:0] current,
	input  wca_pkg::range_t    cur,
	output wca_pkg::range_t    nxt
);

	import wca_pkg::*;

	logic        [SAMPLE_W-1:0] gv;
	logic signed [SAMPLE_W-1:0] gi;

	always_comb begin
		gv          = grow_v(voltage);
		gi          = grow_i(current);
		nxt         = cur;
		nxt.started = 1'b1;
		if (voltage > cur.vpeak) begin
			nxt.vpeak = voltage;
		end
		if (current > cur.ipeak) begin
			nxt.ipeak = current;
		end
		if (!cur.started) begin
			// first sample: grown value, but never below the floor
			nxt.vtop = (gv > TOP_FLOOR_V) ? gv : TOP_FLOOR_V;
			nxt.itop = (gi > TOP_FLOOR_I) ? gi : TOP_FLOOR_I;
		end else begin
			if (voltage > cur.vtop) begin
				nxt.vtop = gv;
			end
			if (current > cur.itop) begin
				nxt.itop = gi;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/waveform_capture_autoscale.sv
// ----------------------------------------------------------------------------
// waveform_capture_autoscale: sample history capture with sticky autoscale
// result registered by the input register and the history ram's registered
// read port; one item per cycle while out_ready is high
// async reset clears control state; history reads 0 until written (fill count)
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_capture_autoscale #(
	parameter int HISTORY_DEPTH = wca_pkg::HISTORY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [15:0] sample_voltage,
	input  logic signed [15:0] sample_current,
	input  logic               paused,
	input  logic        [7:0]  read_index,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [15:0] voltage_top,
	output logic signed [15:0] current_top,
	output logic        [15:0] voltage_peak,
	output logic signed [15:0] current_peak,
	output logic        [15:0] held_voltage,
	output logic signed [15:0] held_current,
	output logic        [7:0]  write_slot,
	output logic               has_data,
	output logic        [15:0] read_voltage,
	output logic signed [15:0] read_current
);

	import wca_pkg::*;

	localparam int            AW        = $clog2(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

	// input stage
	logic                       valid_s1;
	logic        [SAMPLE_W-1:0] voltage_s1;
	logic signed [SAMPLE_W-1:0] current_s1;
	logic                       paused_s1;
	logic        [IDX_W-1:0]    read_index_s1;

	// result stage (architectural state doubles as the result register)
	logic                       valid_s2;
	logic                       rvalid_s2;
	logic                       bypass_s2;
	logic        [PAIR_W-1:0]   wdata_s2;

	// architectural state
	logic        [AW-1:0]       wptr_q;
	logic                       wrapped_q;
	logic                       data_q;
	logic                       pause_seen_q;
	logic        [SAMPLE_W-1:0] held_v_q;
	logic signed [SAMPLE_W-1:0] held_i_q;
	range_t                     range_q;

	logic                       adv;
	logic                       capture;
	logic        [AW-1:0]       ridx;
	logic        [AW-1:0]       ridx_lut [2**IDX_W];
	logic        [AW-1:0]       wptr_next;
	logic        [AW-1:0]       wptr_post;
	logic                       wrap_post;
	logic                       rvalid;
	logic                       bypass;
	logic        [PAIR_W-1:0]   wdata;
	logic        [PAIR_W-1:0]   ram_q;
	logic        [PAIR_W-1:0]   rd_pair;
	range_t                     range_nxt;

	// ---------------- handshake ----------------
	// item moves from s1 to s2 when the result slot is free or being drained
	assign adv      = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			voltage_s1    <= sample_voltage;
			current_s1    <= sample_current;
			paused_s1     <= paused;
			read_index_s1 <= read_index;
		end
	end

	// ---------------- read slot folding ----------------
	// read_index modulo depth through a constant table
	for (genvar k = 0; k < 2**IDX_W; k++) begin : g_ridx
		localparam int Slot = k % HISTORY_DEPTH;
		assign ridx_lut[k] = AW'(Slot);
	end

	assign ridx = ridx_lut[read_index_s1];

	// ---------------- write pointer and fill tracking ----------------
	assign capture   = ~paused_s1;
	assign wptr_next = (wptr_q == LAST_SLOT) ? '0 : wptr_q + AW'(1);
	assign wptr_post = capture ? wptr_next : wptr_q;
	assign wrap_post = wrapped_q | (capture & (wptr_q == LAST_SLOT));

	// a slot holds data once written: below the pointer, or anywhere after a wrap
	assign rvalid = wrap_post | (ridx < wptr_post);
	// read of the slot written by this same transfer sees the new pair
	assign bypass = capture & (ridx == wptr_q);
	assign wdata  = {voltage_s1, current_s1};

	wca_range u_range (
		.voltage (voltage_s1),
		.current (current_s1),
		.cur     (range_q),
		.nxt     (range_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q       <= '0;
			wrapped_q    <= 1'b0;
			data_q       <= 1'b0;
			pause_seen_q <= 1'b0;
			held_v_q     <= '0;
			held_i_q     <= '0;
			range_q      <= '0;
			rvalid_s2    <= 1'b0;
			bypass_s2    <= 1'b0;
		end else if (adv) begin
			pause_seen_q <= paused_s1;
			// rising pause edge latches the pair on display
			if (!pause_seen_q && paused_s1) begin
				held_v_q <= voltage_s1;
				held_i_q <= current_s1;
			end
			if (capture) begin
				wptr_q    <= wptr_next;
				wrapped_q <= wrap_post;
				data_q    <= 1'b1;
				range_q   <= range_nxt;
			end
			rvalid_s2 <= rvalid;
			bypass_s2 <= bypass;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wdata_s2 <= wdata;
		end
	end

	// ---------------- history store ----------------
	// voltage in the upper half, current in the lower half
	wca_ram #(
		.WIDTH (PAIR_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (adv & capture),
		.waddr (wptr_q),
		.wdata (wdata),
		.re    (adv),
		.raddr (ridx),
		.rdata (ram_q)
	);

	always_comb begin
		if (!rvalid_s2) begin
			rd_pair = '0;
		end else if (bypass_s2) begin
			rd_pair = wdata_s2;
		end else begin
			rd_pair = ram_q;
		end
	end

	// ---------------- result ----------------
	assign out_valid    = valid_s2;
	assign voltage_top  = range_q.vtop;
	assign current_top  = range_q.itop;
	assign voltage_peak = range_q.vpeak;
	assign current_peak = range_q.ipeak;
	assign held_voltage = held_v_q;
	assign held_current = held_i_q;
	assign write_slot   = 8'(wptr_q);
	assign has_data     = data_q;
	assign read_voltage = rd_pair[PAIR_W-1:SAMPLE_W];
	assign read_current = $signed(rd_pair[SAMPLE_W-1:0]);

`ifndef ASSERT_OFF
	// once capturing, both tops sit at or above the floor
	a_top_floor: assert property (@(posedge clk) disable iff (!arst_n)
		range_q.started |-> (range_q.vtop >= TOP_FLOOR_V && range_q.itop >= TOP_FLOOR_I))
		else $error("display top below floor");

	// sticky tops never shrink
	a_top_mono: assert property (@(posedge clk) disable iff (!arst_n)
		range_q.started |=> (range_q.vtop >= $past(range_q.vtop) &&
			range_q.itop >= $past(range_q.itop)))
		else $error("display top decreased");

	// pointer moves only on a capturing transfer into the result stage
	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && capture) |=> $stable(wptr_q))
		else $error("write pointer moved without a capture");

	// range start and has_data are set by the same first capture
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		range_q.started == data_q)
		else $error("range start and data flag disagree");
`endif

endmodule

`default_nettype wire
